[rtl/dsu_pkg.sv]
// Shared constants, types and control structs of the disjoint-set engine.
`default_nettype none
package dsu_pkg;

  localparam int NUM_ELEMENTS = 64;
  localparam int IDX_W        = $clog2(NUM_ELEMENTS);
  localparam int RANK_W       = 3;
  localparam int HOP_W        = $clog2(NUM_ELEMENTS + 1);

  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};
  localparam logic [HOP_W-1:0]  HOP_LIMIT = HOP_W'(NUM_ELEMENTS);

  typedef enum logic {
    CMD_FIND  = 1'b0,
    CMD_UNION = 1'b1
  } cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_WALK = 5'b00010,
    ST_COMP = 5'b00100,
    ST_RANK = 5'b01000,
    ST_LINK = 5'b10000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // take a new item, start walking from elem_a
    logic walk;      // one hop up the parent chain
    logic comp;      // one step of path compression
    logic phase;     // 0: working on elem_a, 1: on elem_b
    logic next_b;    // save root of elem_a, start walking from elem_b
    logic rank_sel;  // capture rank of first root, read rank of second
    logic link;      // link the two roots and report
    logic fin_find;  // report result of a find
    logic fin_same;  // report union of a set with itself
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic at_root;   // walk has reached the root (or the hop bound)
    logic comp_end;  // compression has reached the root (or the hop bound)
    logic roots_eq;  // both operands share one root
    logic is_union;  // current item is a union
  } sts_t;

endpackage
`default_nettype wire

[rtl/dsu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/dsu_ctrl.sv]
// Sequencer of the disjoint-set engine: walk, compress, rank compare, link.
`default_nettype none
module dsu_ctrl
  import dsu_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire sts_t sts_i,
  output ctl_t      ctl_o
);

  state_e state_q, state_d;
  logic   phase_q, phase_d;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    ctl_o   = '0;
    ctl_o.phase = phase_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          phase_d    = 1'b0;
          state_d    = ST_WALK;
        end
      end
      ST_WALK: begin
        ctl_o.walk = 1'b1;
        if (sts_i.at_root) begin
          state_d = ST_COMP;
        end
      end
      ST_COMP: begin
        ctl_o.comp = 1'b1;
        if (sts_i.comp_end) begin
          if (!phase_q) begin
            if (sts_i.is_union) begin
              ctl_o.next_b = 1'b1;
              phase_d      = 1'b1;
              state_d      = ST_WALK;
            end else begin
              ctl_o.fin_find = 1'b1;
              state_d        = ST_IDLE;
            end
          end else if (sts_i.roots_eq) begin
            ctl_o.fin_same = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            state_d = ST_RANK;
          end
        end
      end
      ST_RANK: begin
        ctl_o.rank_sel = 1'b1;
        state_d        = ST_LINK;
      end
      ST_LINK: begin
        ctl_o.link = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_link_second_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.link |-> phase_q && $past(state_q == ST_RANK))
    else $error("link outside second-operand flow");

endmodule
`default_nettype wire

[rtl/dsu_datapath.sv]
// Datapath: parent and rank tables, chain pointers, result registers.
`default_nettype none
module dsu_datapath
  import dsu_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             command_i,
  input  wire logic [IDX_W-1:0] elem_a_i,
  input  wire logic [IDX_W-1:0] elem_b_i,
  input  wire ctl_t             ctl_i,
  output sts_t                  sts_o,
  output logic      [IDX_W-1:0] root_o,
  output logic                  merged_o,
  output logic                  done_o
);

  // item and walk registers
  logic              cmd_q;
  logic [IDX_W-1:0]  a_q, b_q;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [IDX_W-1:0]  walk_q, walk_d;
  logic [IDX_W-1:0]  ra_q, ra_d;
  logic [HOP_W-1:0]  hops_q, hops_d;
  logic [RANK_W-1:0] rank_a_q, rank_a_d;
  logic [IDX_W-1:0]  root_q, root_d;
  logic              merged_q, merged_d;
  logic              done_q, done_d;

  // table ports
  logic              p_we;
  logic [IDX_W-1:0]  p_waddr, p_wdata, p_raddr, p_ram, p_addr_q, p_data;
  logic              r_we;
  logic [IDX_W-1:0]  r_waddr, r_raddr;
  logic [RANK_W-1:0] r_wdata, r_ram, r_data;

  // an entry never written holds its reset value
  logic [NUM_ELEMENTS-1:0] p_valid_q, r_valid_q;
  logic                    p_vld_q, r_vld_q;

  logic [IDX_W-1:0] origin;
  logic             a_lower;

  dsu_ram #(.WIDTH(IDX_W), .DEPTH(NUM_ELEMENTS)) u_parent (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_ram)
  );

  dsu_ram #(.WIDTH(RANK_W), .DEPTH(NUM_ELEMENTS)) u_rank (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (r_raddr),
    .rdata_o (r_ram)
  );

  assign p_data = p_vld_q ? p_ram : p_addr_q;
  assign r_data = r_vld_q ? r_ram : '0;

  assign origin  = ctl_i.phase ? b_q : a_q;
  assign a_lower = (rank_a_q < r_data);

  assign sts_o.at_root  = (hops_q == HOP_LIMIT) || (p_data == cur_q);
  assign sts_o.comp_end = (hops_q == HOP_LIMIT) || (walk_q == cur_q);
  assign sts_o.roots_eq = (ra_q == cur_q);
  assign sts_o.is_union = (cmd_q == CMD_UNION);

  always_comb begin
    cur_d    = cur_q;
    walk_d   = walk_q;
    ra_d     = ra_q;
    hops_d   = hops_q;
    rank_a_d = rank_a_q;
    root_d   = root_q;
    merged_d = merged_q;
    done_d   = 1'b0;
    p_raddr  = cur_q;
    p_we     = 1'b0;
    p_waddr  = walk_q;
    p_wdata  = cur_q;
    r_raddr  = ctl_i.rank_sel ? cur_q : ra_q;
    r_we     = 1'b0;
    r_waddr  = ra_q;
    r_wdata  = rank_a_q + RANK_W'(1);

    if (ctl_i.load) begin
      cur_d   = elem_a_i;
      hops_d  = '0;
      p_raddr = elem_a_i;
    end

    if (ctl_i.walk) begin
      if (!sts_o.at_root) begin
        cur_d   = p_data;
        hops_d  = hops_q + HOP_W'(1);
        p_raddr = p_data;
      end else begin
        // root found: restart from the origin to rewrite its chain
        walk_d  = origin;
        hops_d  = '0;
        p_raddr = origin;
      end
    end

    if (ctl_i.comp && !sts_o.comp_end) begin
      p_we    = 1'b1;
      walk_d  = p_data;
      hops_d  = hops_q + HOP_W'(1);
      p_raddr = p_data;
    end

    if (ctl_i.next_b) begin
      ra_d    = cur_q;
      cur_d   = b_q;
      hops_d  = '0;
      p_raddr = b_q;
    end

    if (ctl_i.rank_sel) begin
      rank_a_d = r_data;
    end

    if (ctl_i.fin_find || ctl_i.fin_same) begin
      root_d   = cur_q;
      merged_d = 1'b0;
      done_d   = 1'b1;
    end

    if (ctl_i.link) begin
      p_we     = 1'b1;
      merged_d = 1'b1;
      done_d   = 1'b1;
      if (a_lower) begin
        p_waddr = ra_q;
        p_wdata = cur_q;
        root_d  = cur_q;
      end else begin
        p_waddr = cur_q;
        p_wdata = ra_q;
        root_d  = ra_q;
        // equal ranks: first root grows, saturating
        if ((rank_a_q == r_data) && (rank_a_q != RANK_MAX)) begin
          r_we = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= command_i;
      a_q   <= elem_a_i;
      b_q   <= elem_b_i;
    end
    cur_q    <= cur_d;
    walk_q   <= walk_d;
    ra_q     <= ra_d;
    hops_q   <= hops_d;
    rank_a_q <= rank_a_d;
    root_q   <= root_d;
    merged_q <= merged_d;
    p_addr_q <= p_raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= '0;
      r_valid_q <= '0;
      p_vld_q   <= 1'b0;
      r_vld_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      p_vld_q <= p_valid_q[p_raddr];
      r_vld_q <= r_valid_q[r_raddr];
      if (p_we) begin
        p_valid_q[p_waddr] <= 1'b1;
      end
      if (r_we) begin
        r_valid_q[r_waddr] <= 1'b1;
      end
      done_q <= done_d;
    end
  end

  assign root_o   = root_q;
  assign merged_o = merged_q;
  assign done_o   = done_q;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_merged_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merged_o && done_o |-> $past(ctl_i.link))
    else $error("merged reported without a link");

  a_link_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.link |-> !sts_o.roots_eq)
    else $error("link of a root to itself");

endmodule
`default_nettype wire

[rtl/disjoint_set_union_find.sv]
// Top level of the disjoint-set (union-find) engine.
//
// Command port: an item (command_i, elem_a_i, elem_b_i) is taken on a rising
// edge with start high and busy low. command_i low asks for the root of
// elem_a_i; high joins the sets of elem_a_i and elem_b_i by rank.
// Each item gives one result: root_o and merged_o are valid for exactly one
// cycle while done_o is high. The receiver cannot stall; it must sample then.
//
// Timing: the parent table is one RAM with registered read, so the walk and
// the compression step through the chain one entry at a time. A find walks
// to the root and then compresses the path; done_o rises in the same cycle
// that busy falls. A union does this for both operands, then passes through
// a rank read state and a link state; when both operands already share a
// root it ends without them. One item is in work at a time; a new start may
// be given in the cycle that done_o is high.
//
// Reset: every element is its own set with rank zero. Per-entry valid bits
// stand for the reset contents, so the engine is ready on the first cycle.
`default_nettype none
module disjoint_set_union_find
  import dsu_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             command_i,
  input  wire logic [IDX_W-1:0] elem_a_i,
  input  wire logic [IDX_W-1:0] elem_b_i,
  output logic      [IDX_W-1:0] root_o,
  output logic                  merged_o,
  output logic                  done_o
);

  ctl_t ctl;
  sts_t sts;

  dsu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  dsu_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .command_i (command_i),
    .elem_a_i  (elem_a_i),
    .elem_b_i  (elem_b_i),
    .ctl_i     (ctl),
    .sts_o     (sts),
    .root_o    (root_o),
    .merged_o  (merged_o),
    .done_o    (done_o)
  );

endmodule
`default_nettype wire
